[rtl/rli_pkg.sv]
package rli_pkg;

    typedef enum logic [2:0] {
        KIND_TICK      = 3'd0,
        KIND_SET_REC   = 3'd1,
        KIND_COUNTDOWN = 3'd2,
        KIND_SET_LEVEL = 3'd3,
        KIND_SET_CLIP  = 3'd4
    } kind_t;

    localparam int CFG_BITS       = 16;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_FLASH_INTERVAL = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_HOLD      = 2'd1;

    localparam logic [CFG_BITS-1:0] FLASH_INTERVAL_RESET = 16'd250;
    localparam logic [CFG_BITS-1:0] CLIP_HOLD_RESET      = 16'd500;

    // Level is unsigned Q1.15; 328 is the first code above 0.01.
    localparam logic [15:0] LEVEL_ONE         = 16'd32768;
    localparam logic [15:0] LEVEL_MIN_VISIBLE = 16'd328;
    localparam logic [7:0]  MIN_BRIGHT        = 8'd10;
    localparam logic [7:0]  BRIGHT_FULL       = 8'd255;
    localparam logic [7:0]  BRIGHT_OFF        = 8'd0;

    typedef struct packed {
        logic [2:0]  kind;
        logic        flag;
        logic [7:0]  flash_count;
        logic [15:0] level;
    } item_t;

    typedef struct packed {
        logic                      en;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_BITS-1:0]       data;
    } cfg_wr_t;

    typedef struct packed {
        logic blue;
        logic [7:0] pink;
    } leds_t;

    typedef struct packed {
        logic recording;
        logic countdown;
        logic clip;
    } status_t;

endpackage

[rtl/record_led_indicator_unit.sv]
// A transaction accepted at a clock edge is registered, processed at the first edge
// at which the result register may advance; its result is valid from that edge on.
// Throughput: one transaction per cycle unless stalled, set by one update per item.
// Reset (rst_n, asynchronous, active low) clears time, countdown, clip and LED state
// and loads the flash interval with 250 ms and the clip hold with 500 ms.
module record_led_indicator_unit #(
    parameter int TIME_BITS     = 32,
    parameter int BLINK_HALF_MS = 100
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [2:0]                         kind,
    input  logic                               flag,
    input  logic [7:0]                         flash_count,
    input  logic [15:0]                        level,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               blue_on,
    output logic [7:0]                         pink_level,
    input  logic                               cfg_we,
    input  logic [rli_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rli_pkg::CFG_BITS-1:0]       cfg_data
);

    logic             in_valid_reg;
    rli_pkg::item_t   item_reg;
    logic             out_valid_reg;
    logic             advance;
    logic             exec;
    rli_pkg::cfg_wr_t cfg_wr;
    rli_pkg::leds_t   leds;
    rli_pkg::status_t status;

    // The held LED state is the result register; it moves only when the
    // previous result has been taken or was never there.
    assign advance  = !out_valid_reg || !out_stall;
    assign exec     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    assign cfg_wr.en    = cfg_we;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.kind        <= kind;
            item_reg.flag        <= flag;
            item_reg.flash_count <= flash_count;
            item_reg.level       <= level;
        end
    end

    rli_core #(
        .TIME_BITS     (TIME_BITS),
        .BLINK_HALF_MS (BLINK_HALF_MS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .exec   (exec),
        .item   (item_reg),
        .cfg_wr (cfg_wr),
        .leds   (leds),
        .status (status)
    );

    assign out_valid  = out_valid_reg;
    assign blue_on    = leds.blue;
    assign pink_level = leds.pink;

    a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec |=> out_valid_reg)
        else $error("processed transaction did not produce a result");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a pending transaction");

    a_blue_has_owner: assert property (@(posedge clk) disable iff (!rst_n)
        leds.blue |-> (status.recording || status.countdown))
        else $error("recording LED lit with neither recording nor countdown");

endmodule

[rtl/rli_bright.sv]
module rli_bright (
    input  logic [15:0] level,
    output logic [7:0]  bright
);

    logic [15:0] level_sat;
    logic [30:0] square;
    logic [38:0] scaled;
    logic [7:0]  raw;

    assign level_sat = (level > rli_pkg::LEVEL_ONE) ? rli_pkg::LEVEL_ONE : level;
    assign square    = {15'd0, level_sat} * {15'd0, level_sat};
    // Multiplying by 255 is a shift and a subtract.
    assign scaled    = {square, 8'd0} - {8'd0, square};
    assign raw       = scaled[37:30];

    always_comb
    begin
        if (level_sat >= rli_pkg::LEVEL_MIN_VISIBLE && raw < rli_pkg::MIN_BRIGHT)
        begin
            bright = rli_pkg::MIN_BRIGHT;
        end
        else
        begin
            bright = raw;
        end
    end

endmodule

[rtl/rli_core.sv]
module rli_core #(
    parameter int TIME_BITS     = 32,
    parameter int BLINK_HALF_MS = 100
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              exec,
    input  rli_pkg::item_t    item,
    input  rli_pkg::cfg_wr_t  cfg_wr,
    output rli_pkg::leds_t    leds,
    output rli_pkg::status_t  status
);

    localparam int HC_BITS = $clog2(BLINK_HALF_MS);

    logic [rli_pkg::CFG_BITS-1:0] flash_interval_reg;
    logic [rli_pkg::CFG_BITS-1:0] clip_hold_reg;

    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [HC_BITS-1:0]   hc_reg, hc_next;
    logic                 bp_reg, bp_next;
    logic                 rec_reg, rec_next;
    logic                 cd_reg, cd_next;
    logic [7:0]           fl_reg, fl_next;
    logic [TIME_BITS-1:0] last_toggle_reg, last_toggle_next;
    logic                 fp_reg, fp_next;
    logic [7:0]           bright_reg, bright_next;
    logic                 clip_reg, clip_next;
    logic [TIME_BITS-1:0] clip_start_reg, clip_start_next;
    logic                 blue_reg, blue_next;
    logic [7:0]           pink_reg, pink_next;

    logic [7:0]           item_bright;
    logic [TIME_BITS-1:0] now_inc;
    logic [HC_BITS:0]     hc_inc;
    logic [TIME_BITS-1:0] toggle_elapsed;
    logic [TIME_BITS-1:0] clip_elapsed;

    rli_bright u_bright (
        .level  (item.level),
        .bright (item_bright)
    );

    assign now_inc        = now_reg + TIME_BITS'(1);
    assign hc_inc         = {1'b0, hc_reg} + (HC_BITS+1)'(1);
    assign toggle_elapsed = now_inc - last_toggle_reg;
    assign clip_elapsed   = now_inc - clip_start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_interval_reg <= rli_pkg::FLASH_INTERVAL_RESET;
            clip_hold_reg      <= rli_pkg::CLIP_HOLD_RESET;
        end
        else if (cfg_wr.en)
        begin
            if (cfg_wr.index == rli_pkg::CFG_FLASH_INTERVAL)
            begin
                flash_interval_reg <= cfg_wr.data;
            end
            else if (cfg_wr.index == rli_pkg::CFG_CLIP_HOLD)
            begin
                clip_hold_reg <= cfg_wr.data;
            end
        end
    end

    always_comb
    begin
        now_next         = now_reg;
        hc_next          = hc_reg;
        bp_next          = bp_reg;
        rec_next         = rec_reg;
        cd_next          = cd_reg;
        fl_next          = fl_reg;
        last_toggle_next = last_toggle_reg;
        fp_next          = fp_reg;
        bright_next      = bright_reg;
        clip_next        = clip_reg;
        clip_start_next  = clip_start_reg;
        blue_next        = blue_reg;
        pink_next        = pink_reg;

        if (exec)
        begin
            unique case (rli_pkg::kind_t'(item.kind))
                rli_pkg::KIND_TICK:
                begin
                    now_next = now_inc;
                    // The phase counter restarts whenever the time wraps to zero.
                    if (now_inc == '0)
                    begin
                        hc_next = '0;
                        bp_next = 1'b0;
                    end
                    else if (hc_inc >= (HC_BITS+1)'(BLINK_HALF_MS))
                    begin
                        hc_next = '0;
                        bp_next = !bp_reg;
                    end
                    else
                    begin
                        hc_next = hc_inc[HC_BITS-1:0];
                    end

                    if (cd_reg && toggle_elapsed > TIME_BITS'(flash_interval_reg))
                    begin
                        fp_next          = !fp_reg;
                        blue_next        = !fp_reg;
                        last_toggle_next = now_inc;
                        // An off-phase uses up one flash; the countdown ends at zero.
                        if (fp_reg)
                        begin
                            if (fl_reg <= 8'd1)
                            begin
                                fl_next   = '0;
                                cd_next   = 1'b0;
                                blue_next = 1'b0;
                            end
                            else
                            begin
                                fl_next = fl_reg - 8'd1;
                            end
                        end
                    end

                    if (rec_reg)
                    begin
                        if (clip_reg)
                        begin
                            pink_next = !bp_next ? rli_pkg::BRIGHT_FULL : rli_pkg::BRIGHT_OFF;
                            if (clip_elapsed > TIME_BITS'(clip_hold_reg))
                            begin
                                clip_next = 1'b0;
                            end
                        end
                        else
                        begin
                            pink_next = bright_reg;
                        end
                    end
                end
                rli_pkg::KIND_SET_REC:
                begin
                    rec_next  = item.flag;
                    cd_next   = 1'b0;
                    blue_next = item.flag;
                    if (!item.flag)
                    begin
                        pink_next = rli_pkg::BRIGHT_OFF;
                    end
                end
                rli_pkg::KIND_COUNTDOWN:
                begin
                    cd_next          = 1'b1;
                    fl_next          = item.flash_count;
                    last_toggle_next = now_reg;
                    fp_next          = 1'b1;
                    blue_next        = 1'b1;
                end
                rli_pkg::KIND_SET_LEVEL:
                begin
                    bright_next = item_bright;
                    if (rec_reg && !clip_reg)
                    begin
                        pink_next = item_bright;
                    end
                end
                rli_pkg::KIND_SET_CLIP:
                begin
                    if (item.flag && !clip_reg)
                    begin
                        clip_next       = 1'b1;
                        clip_start_next = now_reg;
                    end
                    else if (!item.flag)
                    begin
                        clip_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg         <= '0;
            hc_reg          <= '0;
            bp_reg          <= 1'b0;
            rec_reg         <= 1'b0;
            cd_reg          <= 1'b0;
            fl_reg          <= '0;
            last_toggle_reg <= '0;
            fp_reg          <= 1'b0;
            bright_reg      <= '0;
            clip_reg        <= 1'b0;
            clip_start_reg  <= '0;
            blue_reg        <= 1'b0;
            pink_reg        <= '0;
        end
        else
        begin
            now_reg         <= now_next;
            hc_reg          <= hc_next;
            bp_reg          <= bp_next;
            rec_reg         <= rec_next;
            cd_reg          <= cd_next;
            fl_reg          <= fl_next;
            last_toggle_reg <= last_toggle_next;
            fp_reg          <= fp_next;
            bright_reg      <= bright_next;
            clip_reg        <= clip_next;
            clip_start_reg  <= clip_start_next;
            blue_reg        <= blue_next;
            pink_reg        <= pink_next;
        end
    end

    assign leds.blue        = blue_reg;
    assign leds.pink        = pink_reg;
    assign status.recording = rec_reg;
    assign status.countdown = cd_reg;
    assign status.clip      = clip_reg;

endmodule
